[design/are_pkg.sv]
// Shared types, constants and the control store for the 16-bit arithmetic encoder.
// Used by are_seq, are_dp, are_out and the top level; no dependencies.
package are_pkg;

    localparam int unsigned STEP_W = 4;

    localparam logic [15:0] HALF          = 16'd32768;
    localparam logic [15:0] QUARTER       = 16'd16384;
    localparam logic [15:0] THREE_QUARTER = 16'd49152;
    localparam logic [15:0] TOP           = 16'd65535;
    localparam logic [14:0] CF_MAX        = 15'd16384;
    localparam int unsigned FRAC_BITS     = 14;

    // request kinds
    localparam logic [1:0] ACT_ENCODE = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_START  = 2'd2;

    // microprogram addresses
    localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] ST_START  = 4'd1;
    localparam logic [STEP_W-1:0] ST_FIN    = 4'd2;
    localparam logic [STEP_W-1:0] ST_FLUSH  = 4'd3;
    localparam logic [STEP_W-1:0] ST_RANGE  = 4'd4;
    localparam logic [STEP_W-1:0] ST_MULU   = 4'd5;
    localparam logic [STEP_W-1:0] ST_MULL   = 4'd6;
    localparam logic [STEP_W-1:0] ST_SETL   = 4'd7;
    localparam logic [STEP_W-1:0] ST_RENORM = 4'd8;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_FINISH,
        OP_FLUSH,
        OP_RANGE,
        OP_MULU,
        OP_MULL,
        OP_SETL,
        OP_RENORM
    } t_op;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_LOOP,
        SEQ_DISPATCH
    } t_seq;

    typedef struct packed {
        t_op               op;
        t_seq              seq;
        logic [STEP_W-1:0] target;
        logic              uses_out;
    } t_ctrl;

    typedef struct packed {
        logic [31:0] total;
        logic [15:0] follow;
        logic        lead;
    } t_run;

    typedef struct packed {
        logic renorm_done;
    } t_dp_stat;

    function automatic t_ctrl ctrl_rom(input logic [STEP_W-1:0] step);
        t_ctrl cw;
        cw = '{op: OP_NOP, seq: SEQ_GOTO, target: ST_IDLE, uses_out: 1'b0};
        unique case (step)
            ST_IDLE:   cw = '{op: OP_NOP,    seq: SEQ_DISPATCH, target: ST_IDLE,  uses_out: 1'b0};
            ST_START:  cw = '{op: OP_CLEAR,  seq: SEQ_GOTO,     target: ST_IDLE,  uses_out: 1'b0};
            ST_FIN:    cw = '{op: OP_FINISH, seq: SEQ_NEXT,     target: ST_IDLE,  uses_out: 1'b1};
            ST_FLUSH:  cw = '{op: OP_FLUSH,  seq: SEQ_GOTO,     target: ST_IDLE,  uses_out: 1'b1};
            ST_RANGE:  cw = '{op: OP_RANGE,  seq: SEQ_NEXT,     target: ST_IDLE,  uses_out: 1'b0};
            ST_MULU:   cw = '{op: OP_MULU,   seq: SEQ_NEXT,     target: ST_IDLE,  uses_out: 1'b0};
            ST_MULL:   cw = '{op: OP_MULL,   seq: SEQ_NEXT,     target: ST_IDLE,  uses_out: 1'b0};
            ST_SETL:   cw = '{op: OP_SETL,   seq: SEQ_NEXT,     target: ST_IDLE,  uses_out: 1'b0};
            ST_RENORM: cw = '{op: OP_RENORM, seq: SEQ_LOOP,     target: ST_FLUSH, uses_out: 1'b1};
            default:   cw = '{op: OP_NOP,    seq: SEQ_GOTO,     target: ST_IDLE,  uses_out: 1'b0};
        endcase
        return cw;
    endfunction

endpackage

[design/arithmetic_range_encoder_16bit.sv]
// Top level of the 16-bit integer arithmetic encoder.
// Depends on are_pkg, are_seq, are_dp and are_out.
//
// Usage:
//  - Slave stream takes one request per handshake: tuser = action (encode, finish,
//    start), tdata = has_upper, cf_upper, cf_lower. Frequencies above 16384 clamp.
//  - Master stream gives one run per handshake: lead bit, follow count and the
//    running bit total; tlast marks the final run caused by a request.
//  - A microprogram sequences each request: encode runs range, upper and lower product,
//    set-low, then 1..16 renormalisation steps (one per cycle unless the output stalls)
//    and flush; finish runs finish and flush; start clears; unused actions are dropped.
//  - Each run is held one slot back until the next run or the end of the request
//    decides tlast; the last run enters the output register in the cycle after the flush step.
//  - The next request is accepted while the final run still waits in the output
//    register.
//  - If the receiver stalls with both output slots full, the sequencer freezes on
//    any renormalisation, finish or flush step, and resumes with nothing lost.
//  - Synchronous active-low reset returns the interval to [0, 65535], clears the
//    pending count and bit total, and empties the output slots.
module arithmetic_range_encoder_16bit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [0] has_upper, [15:1] cf_upper, [30:16] cf_lower
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [0] lead_bit, [16:1] follow_count, [48:17] total_bits
    output logic        m_axis_tlast
);
    import are_pkg::*;

    t_ctrl    w_ctrl;
    t_dp_stat w_stat;
    t_run     w_run, w_out_run;
    logic     w_en, w_ready, w_load, w_push, w_flush, w_can_accept;

    assign s_axis_tready = w_ready;
    assign w_load        = s_axis_tvalid && w_ready;

    are_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_vld    (s_axis_tvalid),
        .i_action     (s_axis_tuser),
        .i_can_accept (w_can_accept),
        .i_stat       (w_stat),
        .o_ctrl       (w_ctrl),
        .o_en         (w_en),
        .o_ready      (w_ready)
    );

    are_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_has_upper (s_axis_tdata[0]),
        .i_cf_upper  (s_axis_tdata[15:1]),
        .i_cf_lower  (s_axis_tdata[30:16]),
        .i_ctrl      (w_ctrl),
        .i_en        (w_en),
        .o_stat      (w_stat),
        .o_push      (w_push),
        .o_flush     (w_flush),
        .o_run       (w_run)
    );

    are_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_flush      (w_flush),
        .i_run        (w_run),
        .i_ready      (m_axis_tready),
        .o_can_accept (w_can_accept),
        .o_vld        (m_axis_tvalid),
        .o_run        (w_out_run),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, w_out_run.total, w_out_run.follow, w_out_run.lead};

endmodule

[design/are_seq.sv]
// Microsequencer: step counter, control store lookup and jump logic.
// Depends on are_pkg.
module are_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_vld,
    input  logic [1:0]            i_action,
    input  logic                  i_can_accept,
    input  are_pkg::t_dp_stat     i_stat,
    output are_pkg::t_ctrl        o_ctrl,
    output logic                  o_en,
    output logic                  o_ready
);
    import are_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             w_cw;
    logic              w_stall;

    assign w_cw    = ctrl_rom(r_step);
    assign w_stall = w_cw.uses_out && !i_can_accept;
    assign o_ctrl  = w_cw;
    assign o_en    = !w_stall;
    assign o_ready = (r_step == ST_IDLE);

    always_comb begin
        n_step = r_step;
        if (!w_stall) begin
            unique case (w_cw.seq)
                SEQ_NEXT: n_step = r_step + 4'd1;
                SEQ_GOTO: n_step = w_cw.target;
                SEQ_LOOP: begin
                    if (i_stat.renorm_done) begin
                        n_step = w_cw.target;
                    end
                end
                SEQ_DISPATCH: begin
                    if (i_req_vld) begin
                        case (i_action)
                            ACT_ENCODE: n_step = ST_RANGE;
                            ACT_FINISH: n_step = ST_FIN;
                            ACT_START:  n_step = ST_START;
                            default:    n_step = ST_IDLE;
                        endcase
                    end
                end
                default: n_step = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> r_step == $past(r_step))
        else $error("step advanced while stalled");
    a_start_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == ST_START |=> r_step == ST_IDLE)
        else $error("start step did not return to idle");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_RENORM) && !i_stat.renorm_done && !w_stall |=> !o_ready)
        else $error("ready raised during renormalisation");

endmodule

[design/are_dp.sv]
// Datapath: interval bounds, pending count, bit total, shared multiplier, renormaliser.
// Depends on are_pkg; driven one control word per cycle by are_seq, with i_en low while it stalls.
module are_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_has_upper,
    input  logic [14:0]        i_cf_upper,
    input  logic [14:0]        i_cf_lower,
    input  are_pkg::t_ctrl     i_ctrl,
    input  logic               i_en,
    output are_pkg::t_dp_stat  o_stat,
    output logic               o_push,
    output logic               o_flush,
    output are_pkg::t_run      o_run
);
    import are_pkg::*;

    logic [15:0] r_low, r_high, r_pend;
    logic [31:0] r_total;
    logic [16:0] r_range;
    logic [15:0] r_prod;
    logic [14:0] r_cfu, r_cfl;
    logic        r_has_upper;
    logic [3:0]  r_iter;

    logic [31:0] w_mul;
    logic        w_emit, w_lead, w_stop, w_under;
    logic [15:0] w_follow, w_pend_inc;
    logic [31:0] w_total;

    assign w_mul = {15'd0, r_range} * {17'd0, (i_ctrl.op == OP_MULU) ? r_cfu : r_cfl};

    assign w_pend_inc = (r_pend == TOP) ? TOP : r_pend + 16'd1;
    assign w_under    = (r_low >= QUARTER) && (r_high < THREE_QUARTER);
    assign w_stop     = r_high[15] && !r_low[15] && !w_under;

    always_comb begin
        w_emit   = 1'b0;
        w_lead   = 1'b0;
        w_follow = r_pend;
        if (i_ctrl.op == OP_FINISH) begin
            w_emit   = 1'b1;
            w_lead   = (r_low >= QUARTER);
            w_follow = w_pend_inc;
        end else if (i_ctrl.op == OP_RENORM) begin
            w_emit = !r_high[15] || r_low[15];
            w_lead = r_high[15];
        end
    end

    assign w_total = r_total + 32'd1 + {16'd0, w_follow};

    assign o_push          = i_en && w_emit;
    assign o_flush         = i_en && (i_ctrl.op == OP_FLUSH);
    assign o_run           = '{total: w_total, follow: w_follow, lead: w_lead};
    assign o_stat.renorm_done = w_stop || (r_iter == 4'hF);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_has_upper <= i_has_upper;
            r_cfu       <= (i_cf_upper > CF_MAX) ? CF_MAX : i_cf_upper;
            r_cfl       <= (i_cf_lower > CF_MAX) ? CF_MAX : i_cf_lower;
        end
        if (i_en) begin
            case (i_ctrl.op)
                OP_RANGE: r_range <= {1'b0, r_high} - {1'b0, r_low} + 17'd1;
                OP_MULU, OP_MULL: r_prod <= w_mul[FRAC_BITS+15:FRAC_BITS];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '0;
            r_high  <= TOP;
            r_pend  <= '0;
            r_total <= '0;
            r_iter  <= '0;
        end else if (i_en) begin
            if (w_emit) begin
                r_total <= w_total;
            end
            case (i_ctrl.op)
                OP_CLEAR: begin
                    r_low   <= '0;
                    r_high  <= TOP;
                    r_pend  <= '0;
                    r_total <= '0;
                end
                OP_FINISH: r_pend <= '0;
                OP_MULL: begin
                    if (r_has_upper) begin
                        r_high <= r_low + r_prod - 16'd1;
                    end
                end
                OP_SETL: begin
                    r_low  <= r_low + r_prod;
                    r_iter <= '0;
                end
                OP_RENORM: begin
                    r_iter <= r_iter + 4'd1;
                    if (!r_high[15]) begin
                        r_pend <= '0;
                        r_low  <= {r_low[14:0], 1'b0};
                        r_high <= {r_high[14:0], 1'b1};
                    end else if (r_low[15]) begin
                        r_pend <= '0;
                        r_low  <= {r_low[14:0], 1'b0};
                        r_high <= {r_high[14:0], 1'b1};
                    end else if (w_under) begin
                        r_pend <= w_pend_inc;
                        r_low  <= {r_low[14:0] - QUARTER[14:0], 1'b0};
                        r_high <= {r_high[14:0] - QUARTER[14:0], 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[design/are_out.sv]
// Output stage: holds the newest run until its successor or the flush settles tlast.
// Depends on are_pkg.
module are_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic           i_flush,
    input  are_pkg::t_run  i_run,
    input  logic           i_ready,
    output logic           o_can_accept,
    output logic           o_vld,
    output are_pkg::t_run  o_run,
    output logic           o_last
);
    import are_pkg::*;

    logic r_hold_vld, r_out_vld, r_out_last;
    t_run r_hold, r_out;
    logic w_move;

    assign o_can_accept = !r_hold_vld || !r_out_vld || i_ready;
    assign w_move       = r_hold_vld && (i_push || i_flush);
    assign o_vld        = r_out_vld;
    assign o_run        = r_out;
    assign o_last       = r_out_last;

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out      <= r_hold;
            r_out_last <= i_flush;
        end
        if (i_push) begin
            r_hold <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_push) begin
                r_hold_vld <= 1'b1;
            end else if (i_flush) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push || i_flush) |-> o_can_accept)
        else $error("run offered with no room");
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_flush |=> !r_hold_vld)
        else $error("hold slot still full after flush");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && i_flush))
        else $error("push and flush together");

endmodule
